/* src/kdcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdcs_pkg
// Shared types, codes and fixed-point helpers for the cursor subdivider core.
// ----------------------------------------------------------------------------
package kdcs_pkg;

  // Q1.15 values, 1.0 = 32768
  typedef logic [15:0] q15_t;
  localparam q15_t Q_ONE  = 16'h8000;
  localparam q15_t Q_HALF = 16'h4000;

  // Opcodes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_MOVE  = 3'd1;
  localparam logic [2:0] OP_RESET = 3'd2;
  localparam logic [2:0] OP_LOCAL = 3'd3;
  localparam logic [2:0] OP_DANCE = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 3'd4;

  // Register reset values
  localparam q15_t RST_STRIDE_GAIN = 16'd16384;
  localparam q15_t RST_SHRINK_GAIN = 16'd16384;
  localparam q15_t RST_MIN_SCALE   = 16'd328;
  localparam q15_t RST_LOCAL_SCALE = 16'd4096;
  localparam logic [15:0] RST_STEP_LENGTH = 16'd100;

  // Last ring step of the animation
  localparam logic [15:0] RING_LAST = 16'd8;

  // Direction codes (2-bit signed)
  localparam logic [1:0] DIR_Z = 2'b00;
  localparam logic [1:0] DIR_P = 2'b01;
  localparam logic [1:0] DIR_N = 2'b11;

  // Divider length
  localparam int DIV_W = 16;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // What the result word carries
  typedef enum logic [1:0] {
    RES_NONE,
    RES_KEY,
    RES_TICK
  } res_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;          // latch input word
    logic      mul_start;     // product <= step * factor
    logic      mul_rescale;   // factor select: rescale instead of move
    logic      div_start;     // start elapsed / step_length
    logic      apply_move;    // update cursor from product
    logic      apply_step;    // update step size from product
    logic      apply_reset;
    logic      apply_local;
    logic      apply_dance;
    logic      out_load;      // load the result register
    res_kind_t res_kind;
  } kdcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       pressed;
    logic       anim_active;
    logic       div_done;
    logic       out_free;
  } kdcs_status_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
  } ring_t;

  // 8-direction ring, starting and ending at up
  function automatic ring_t ring_dir(logic [3:0] q);
    ring_t r;
    case (q)
      4'd0:    r = '{dx: DIR_Z, dy: DIR_N};
      4'd1:    r = '{dx: DIR_P, dy: DIR_N};
      4'd2:    r = '{dx: DIR_P, dy: DIR_Z};
      4'd3:    r = '{dx: DIR_P, dy: DIR_P};
      4'd4:    r = '{dx: DIR_Z, dy: DIR_P};
      4'd5:    r = '{dx: DIR_N, dy: DIR_P};
      4'd6:    r = '{dx: DIR_N, dy: DIR_Z};
      4'd7:    r = '{dx: DIR_N, dy: DIR_N};
      4'd8:    r = '{dx: DIR_Z, dy: DIR_N};
      default: r = '{dx: DIR_Z, dy: DIR_Z};
    endcase
    return r;
  endfunction

  // pos +/- round(prod * |dir| / 32768), clamped to 0..1.0
  function automatic q15_t axis_move(q15_t pos, logic [31:0] prod, logic [1:0] dir);
    logic [32:0] mag;
    logic [33:0] sum;
    logic [18:0] delta;
    logic [19:0] up;
    q15_t        r;
    case (dir)
      2'b01, 2'b11: mag = {1'b0, prod};
      2'b10:        mag = {prod, 1'b0};
      default:      mag = '0;
    endcase
    sum   = {1'b0, mag} + 34'(Q_HALF);
    delta = sum[33:15];
    up    = {4'b0, pos} + {1'b0, delta};
    if (dir[1]) begin
      if ({3'b0, pos} < delta) r = '0;
      else r = pos - delta[15:0];
    end else begin
      if (up > 20'(Q_ONE)) r = Q_ONE;
      else r = up[15:0];
    end
    return r;
  endfunction

endpackage

/* src/key_driven_cursor_subdivider_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_driven_cursor_subdivider_core
// Keyboard-driven absolute pointer with step subdivision and ring preview.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per key event or timer tick. tuser = opcode, pressed;
//           tdata = dir_x, dir_y, now_time.
//   out_* : exactly one result word per input word, in order.
//   cfg_* : register writes (index 0..4), always ready; write only while the
//           core is idle.
// Sequencing: one word at a time. Reset, local, idle-tick and pass-through
//   words go from decode straight to the result register; a move press makes
//   two passes through the shared multiplier and a tick during the animation
//   runs a serial divide of elapsed/step_length first. The next word is taken
//   on the cycle after the result is loaded.
// Reset (rst_n low, synchronous): cursor and step go to one half, animation
//   stops, registers return to their defaults, no result is pending.
// Back-pressure: a result holds in the output register while out_tready is
//   low; the core still accepts and works on the next word, and waits only
//   when that word's result is ready to load.
// ----------------------------------------------------------------------------
module key_driven_cursor_subdivider_core
  import kdcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // dir_x[1:0], dir_y[3:2], now_time[19:4], zeros
  input  logic [3:0]           in_tuser,   // opcode[2:0], pressed[3]
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // pos_x[15:0], pos_y[31:16], in_range_set[32],
                                           // key_consumed[33], animating[34], zeros
  output logic [0:0]           out_tuser,  // position_sent[0]
  // config writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  kdcs_cmd_t    cmd;
  kdcs_status_t status;
  logic         position_sent, in_range_set, key_consumed, animating;
  q15_t         pos_x, pos_y;

  assign cfg_ready = 1'b1;

  kdcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  kdcs_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (in_tuser[2:0]),
    .pressed       (in_tuser[3]),
    .dir_x         (in_tdata[1:0]),
    .dir_y         (in_tdata[3:2]),
    .now_time      (in_tdata[19:4]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .position_sent (position_sent),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .in_range_set  (in_range_set),
    .key_consumed  (key_consumed),
    .animating     (animating),
    .cmd           (cmd),
    .status        (status)
  );

  // Result word packing
  assign out_tdata = {5'b0, animating, key_consumed, in_range_set, pos_y, pos_x};
  assign out_tuser = position_sent;

endmodule

/* src/kdcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdcs_ctrl
// Sequencer: decodes each accepted word and steps the datapath through it.
// ----------------------------------------------------------------------------
module kdcs_ctrl
  import kdcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  kdcs_status_t status,
  output kdcs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_A,
    S_MOVE_B,
    S_DIV,
    S_FIN
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.res_kind = kind_r;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        kind_nxt  = RES_NONE;
        state_nxt = S_FIN;
        case (status.opcode)
          OP_TICK: begin
            if (status.anim_active) begin
              cmd.mul_start = 1'b1;
              cmd.div_start = 1'b1;
              kind_nxt      = RES_TICK;
              state_nxt     = S_DIV;
            end
          end
          OP_MOVE: begin
            if (status.pressed) begin
              cmd.mul_start = 1'b1;
              kind_nxt      = RES_KEY;
              state_nxt     = S_MOVE_A;
            end
          end
          OP_RESET: begin
            if (status.pressed) begin
              cmd.apply_reset = 1'b1;
              kind_nxt        = RES_KEY;
            end
          end
          OP_LOCAL: begin
            if (status.pressed) begin
              cmd.apply_local = 1'b1;
              kind_nxt        = RES_KEY;
            end
          end
          OP_DANCE: begin
            cmd.apply_dance = status.pressed;
          end
          default: begin
            kind_nxt = RES_NONE;
          end
        endcase
      end
      S_MOVE_A: begin
        // cursor from step*stride gain, then start step*shrink gain
        cmd.apply_move  = 1'b1;
        cmd.mul_start   = 1'b1;
        cmd.mul_rescale = 1'b1;
        state_nxt       = S_MOVE_B;
      end
      S_MOVE_B: begin
        cmd.apply_step = 1'b1;
        state_nxt      = S_FIN;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= RES_NONE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

/* src/kdcs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdcs_datapath
// Config registers, cursor state, shared multiplier, serial divider and the
// result register.
// ----------------------------------------------------------------------------
module kdcs_datapath
  import kdcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // input word fields
  input  logic [2:0]           opcode,
  input  logic                 pressed,
  input  logic [1:0]           dir_x,
  input  logic [1:0]           dir_y,
  input  logic [15:0]          now_time,
  // result
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic                 position_sent,
  output q15_t                 pos_x,
  output q15_t                 pos_y,
  output logic                 in_range_set,
  output logic                 key_consumed,
  output logic                 animating,
  // control
  input  kdcs_cmd_t            cmd,
  output kdcs_status_t         status
);

  // Config
  q15_t        stride_gain_r, shrink_gain_r, min_scale_r, local_scale_r;
  logic [15:0] step_length_r;

  // Block state
  q15_t        cursor_x_r, cursor_y_r, step_r;
  logic        anim_r;
  logic [15:0] start_r;

  // Latched word
  logic [2:0]  op_r;
  logic        pressed_r;
  logic [1:0]  dx_r, dy_r;
  logic [15:0] now_r;

  // Arithmetic
  logic [31:0]      prod_r;
  logic [DIV_W-1:0] rem_r, quo_r, rem_nxt, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W:0]   div_shift;
  logic [DIV_W+1:0] div_trial;

  // Result register
  logic        out_valid_r, sent_r, inr_r, cons_r, anim_out_r;
  q15_t        px_r, py_r;

  // Derived values
  q15_t        mv_x, mv_y, step_nxt, local_cl, tick_x, tick_y;
  logic [32:0] step_sum;
  logic [17:0] step_q, step_fl;
  logic        beyond;
  ring_t       ring;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_gain_r <= RST_STRIDE_GAIN;
      shrink_gain_r <= RST_SHRINK_GAIN;
      min_scale_r   <= RST_MIN_SCALE;
      local_scale_r <= RST_LOCAL_SCALE;
      step_length_r <= RST_STEP_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRIDE_GAIN: stride_gain_r <= cfg_data;
        CFG_SHRINK_GAIN: shrink_gain_r <= cfg_data;
        CFG_MIN_SCALE:   min_scale_r   <= cfg_data;
        CFG_LOCAL_SCALE: local_scale_r <= cfg_data;
        CFG_STEP_LENGTH: step_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= opcode;
      pressed_r <= pressed;
      dx_r      <= dir_x;
      dy_r      <= dir_y;
      now_r     <= now_time;
    end
  end

  // Shared 16x16 multiplier, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= 32'(step_r) * 32'(cmd.mul_rescale ? shrink_gain_r : stride_gain_r);
    end
  end

  // Cursor moves and step update
  assign mv_x     = axis_move(cursor_x_r, prod_r, dx_r);
  assign mv_y     = axis_move(cursor_y_r, prod_r, dy_r);
  assign step_sum = {1'b0, prod_r} + 33'(Q_HALF);
  assign step_q   = step_sum[32:15];
  assign step_fl  = (step_q < {2'b0, min_scale_r}) ? {2'b0, min_scale_r} : step_q;
  assign step_nxt = (step_fl > 18'(Q_ONE)) ? Q_ONE : step_fl[15:0];
  assign local_cl = (local_scale_r > Q_ONE) ? Q_ONE : local_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= Q_HALF;
      cursor_y_r <= Q_HALF;
      step_r     <= Q_HALF;
      anim_r     <= 1'b0;
      start_r    <= '0;
    end else begin
      if (cmd.apply_move) begin
        cursor_x_r <= mv_x;
        cursor_y_r <= mv_y;
        anim_r     <= 1'b0;
      end
      if (cmd.apply_step) step_r <= step_nxt;
      if (cmd.apply_reset) begin
        cursor_x_r <= Q_HALF;
        cursor_y_r <= Q_HALF;
        step_r     <= Q_HALF;
        anim_r     <= 1'b0;
      end
      if (cmd.apply_local) begin
        step_r <= local_cl;
        anim_r <= 1'b0;
      end
      if (cmd.apply_dance) begin
        start_r <= now_r;
        anim_r  <= 1'b1;
      end
      // animation ends once the ring is done
      if (cmd.out_load && cmd.res_kind == RES_TICK && beyond) anim_r <= 1'b0;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign div_shift = {rem_r, quo_r[DIV_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b0, step_length_r};

  always_comb begin
    if (div_trial[DIV_W+1]) begin
      rem_nxt = div_shift[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end else begin
      rem_nxt = div_trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= now_r - start_r;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Tick position along the ring; past the last step the lookup gives no move
  assign beyond = (step_length_r == '0) || (quo_r > RING_LAST);
  assign ring   = ring_dir(beyond ? 4'hF : quo_r[3:0]);
  assign tick_x = axis_move(cursor_x_r, prod_r, ring.dx);
  assign tick_y = axis_move(cursor_y_r, prod_r, ring.dy);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_kind)
        RES_KEY: begin
          sent_r     <= 1'b1;
          px_r       <= cursor_x_r;
          py_r       <= cursor_y_r;
          inr_r      <= 1'b1;
          cons_r     <= 1'b1;
          anim_out_r <= anim_r;
        end
        RES_TICK: begin
          sent_r     <= 1'b1;
          px_r       <= tick_x;
          py_r       <= tick_y;
          inr_r      <= 1'b0;
          cons_r     <= 1'b0;
          anim_out_r <= anim_r & ~beyond;
        end
        default: begin
          sent_r     <= 1'b0;
          px_r       <= '0;
          py_r       <= '0;
          inr_r      <= 1'b0;
          cons_r     <= 1'b0;
          anim_out_r <= anim_r;
        end
      endcase
    end
  end

  assign out_tvalid    = out_valid_r;
  assign position_sent = sent_r;
  assign pos_x         = px_r;
  assign pos_y         = py_r;
  assign in_range_set  = inr_r;
  assign key_consumed  = cons_r;
  assign animating     = anim_out_r;

  // Status back to the controller
  assign status.opcode      = op_r;
  assign status.pressed     = pressed_r;
  assign status.anim_active = anim_r;
  assign status.div_done    = (cnt_r == '0);
  assign status.out_free    = ~out_valid_r | out_tready;

endmodule

/* src/kdcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdcs_checker
// Port-level checks on the cursor subdivider core, bound to the top level.
// ----------------------------------------------------------------------------
module kdcs_checker
  import kdcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // One word in flight: no accept on the cycle after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // No position reported means zero position fields
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:0] == 32'd0)
    else $error("position fields set without position");

  // A swallowed key always reports a position in range
  a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[32] && out_tuser[0])
    else $error("consumed key without in-range position");

  // Positions stay within 0..1.0
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] <= Q_ONE && out_tdata[31:16] <= Q_ONE)
    else $error("position out of range");

endmodule

bind key_driven_cursor_subdivider_core kdcs_checker u_kdcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
